FILE: rtl/cmta_pkg.sv
package cmta_pkg;

    // Face size limit and derived widths
    localparam int MAX_FACE_DIM = 1024;
    localparam int DIM_W        = $clog2(MAX_FACE_DIM + 1);
    localparam int DIM_RESET    = 512;

    // Fixed field widths
    localparam int DIR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int FACE_W     = 3;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int ADDR_W     = 20;

    // Datapath widths
    localparam int MAG_W = DIR_W + 1;      // magnitude, 2*ma, sc+ma, ma-tc
    localparam int SGN_W = DIR_W + 2;      // signed face coordinates
    localparam int NUM_W = MAG_W + DIM_W;  // dividend (coord * size)
    localparam int QUO_W = DIM_W;          // quotient never exceeds the size

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACE_WIDTH  = 2'd0,
        REG_FACE_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef struct packed {
        logic             valid;
        logic             invalid;
        t_face            face;
        logic [MAG_W-1:0] u;     // sc + ma
        logic [MAG_W-1:0] v;     // ma - tc
        logic [MAG_W-1:0] den;   // 2 * ma
    } t_sel;

    typedef struct packed {
        logic             valid;
        logic             invalid;
        t_face            face;
        logic [NUM_W-1:0] rem_c;
        logic [NUM_W-1:0] rem_r;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo_c;
        logic [QUO_W-1:0] quo_r;
    } t_div;

    typedef struct packed {
        logic             valid;
        logic             invalid;
        t_face            face;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] flip;
    } t_wrap;

    typedef struct packed {
        logic              valid;
        logic              invalid;
        t_face             face;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] addr;
    } t_out;

    // Zero reads as one, oversize reads as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (int'(d) > MAX_FACE_DIM) begin
            r = DIM_W'(MAX_FACE_DIM);
        end else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

endpackage

FILE: rtl/cmta_if.sv
interface cmta_dir_if import cmta_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmta_res_if import cmta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FACE_W-1:0] cube_face;
    logic [COL_W-1:0]  texel_col;
    logic [ROW_W-1:0]  texel_row;
    logic [ADDR_W-1:0] texel_address;
    logic              invalid;

    modport source (output valid, output cube_face, output texel_col, output texel_row,
                    output texel_address, output invalid, input ready);
    modport sink   (input valid, input cube_face, input texel_col, input texel_row,
                    input texel_address, input invalid, output ready);
endinterface

interface cmta_cfg_if import cmta_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cube_map_texel_address_unit.sv
// Cube map face selection and texel addressing.
//
// i_dir  : one direction vector (signed Q2.14 x, y, z) per transaction.
// o_res  : face index, texel column/row (after repeat wrap) and the linear
//          texel address within the face (row flipped), plus an invalid flag
//          for an all-zero direction (all other fields then read zero).
// i_cfg  : register writes, index 0 face_width, 1 face_height; other indexes
//          are dropped. Always ready. Write only while the unit is drained.
//
// 15 register stages: select, multiply, 11 divider stages (one quotient bit
// each, set by the 11-bit quotient range of a 1024-texel face), wrap/flip,
// address. Throughput is one transaction per cycle while the receiver does
// not stall.
// Reset (synchronous, active low) empties the pipeline and sets both face
// sizes to 512. When the receiver stalls, the whole pipeline holds; i_dir
// stays ready as long as the output register is empty or being drained.
module cube_map_texel_address_unit import cmta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmta_dir_if.sink    i_dir,
    cmta_cfg_if.sink    i_cfg,
    cmta_res_if.source  o_res
);

    // Face sizes, stored already clamped
    logic [DIM_W-1:0] r_face_w;
    logic [DIM_W-1:0] r_face_h;

    // Pipeline registers
    t_sel  r_sel,  n_sel;
    t_div  r_dv [QUO_W+1];     // [0] is the multiply stage, [k] has k quotient bits
    t_div  n_dv [QUO_W+1];
    t_wrap r_wrap, n_wrap;
    t_out  r_out,  n_out;

    logic w_adv;

    // Single stall domain: everything moves when the output slot frees up
    assign w_adv       = !r_out.valid || o_res.ready;
    assign i_dir.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    //--------------------------------------------------------------------
    // Configuration
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_w <= DIM_W'(DIM_RESET);
            r_face_h <= DIM_W'(DIM_RESET);
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_FACE_WIDTH:  r_face_w <= clamp_dim(i_cfg.data);
                REG_FACE_HEIGHT: r_face_h <= clamp_dim(i_cfg.data);
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Stage 1: major axis, face, sc/tc, offsets into [0, 2*ma]
    //--------------------------------------------------------------------
    always_comb begin
        logic signed [SGN_W-1:0] sx, sy, sz, sc, tc, ma;
        logic [MAG_W-1:0]        ax, ay, az, mm;
        logic signed [SGN_W-1:0] su, sv;
        sx = SGN_W'(i_dir.dir_x);
        sy = SGN_W'(i_dir.dir_y);
        sz = SGN_W'(i_dir.dir_z);
        ax = MAG_W'(sx < 0 ? -sx : sx);
        ay = MAG_W'(sy < 0 ? -sy : sy);
        az = MAG_W'(sz < 0 ? -sz : sz);

        n_sel.valid   = i_dir.valid;
        n_sel.invalid = (sx == '0) && (sy == '0) && (sz == '0);

        // Strict compares: ties fall through to Y, then Z
        if (ax > ay && ax > az) begin
            mm = ax;
            tc = -sy;
            if (sx > 0) begin
                n_sel.face = FACE_POS_X;
                sc         = -sz;
            end else begin
                n_sel.face = FACE_NEG_X;
                sc         = sz;
            end
        end else if (ay > az) begin
            mm = ay;
            sc = sx;
            if (sy > 0) begin
                n_sel.face = FACE_POS_Y;
                tc         = sz;
            end else begin
                n_sel.face = FACE_NEG_Y;
                tc         = -sz;
            end
        end else begin
            mm = az;
            tc = -sy;
            if (sz > 0) begin
                n_sel.face = FACE_POS_Z;
                sc         = sx;
            end else begin
                n_sel.face = FACE_NEG_Z;
                sc         = -sx;
            end
        end

        ma        = SGN_W'(mm);
        su        = sc + ma;
        sv        = ma - tc;
        n_sel.u   = MAG_W'(su);
        n_sel.v   = MAG_W'(sv);
        n_sel.den = MAG_W'({mm, 1'b0});
    end

    //--------------------------------------------------------------------
    // Stage 2: scale by face size to form the dividends
    //--------------------------------------------------------------------
    always_comb begin
        n_dv[0].valid   = r_sel.valid;
        n_dv[0].invalid = r_sel.invalid;
        n_dv[0].face    = r_sel.face;
        n_dv[0].rem_c   = NUM_W'(r_sel.u) * NUM_W'(r_face_w);
        n_dv[0].rem_r   = NUM_W'(r_sel.v) * NUM_W'(r_face_h);
        n_dv[0].den     = r_sel.den;
        n_dv[0].quo_c   = '0;
        n_dv[0].quo_r   = '0;
    end

    //--------------------------------------------------------------------
    // Stages 3..13: restoring division, one quotient bit per stage, MSB first.
    // Dividend < den * 2^QUO_W, so the quotient fits.
    //--------------------------------------------------------------------
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int B = QUO_W - 1 - k;
        always_comb begin
            logic [NUM_W-1:0] trial;
            trial = NUM_W'(r_dv[k].den) << B;
            n_dv[k+1] = r_dv[k];
            if (r_dv[k].rem_c >= trial) begin
                n_dv[k+1].rem_c    = r_dv[k].rem_c - trial;
                n_dv[k+1].quo_c[B] = 1'b1;
            end
            if (r_dv[k].rem_r >= trial) begin
                n_dv[k+1].rem_r    = r_dv[k].rem_r - trial;
                n_dv[k+1].quo_r[B] = 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // Stage 14: repeat wrap (quotient equal to size -> 0), vertical flip
    //--------------------------------------------------------------------
    always_comb begin
        logic [DIM_W-1:0] col_w, row_w, flip_w;
        col_w  = (r_dv[QUO_W].quo_c >= r_face_w) ? '0 : r_dv[QUO_W].quo_c;
        row_w  = (r_dv[QUO_W].quo_r >= r_face_h) ? '0 : r_dv[QUO_W].quo_r;
        flip_w = r_face_h - DIM_W'(1) - row_w;
        n_wrap.valid   = r_dv[QUO_W].valid;
        n_wrap.invalid = r_dv[QUO_W].invalid;
        n_wrap.face    = r_dv[QUO_W].face;
        n_wrap.col     = COL_W'(col_w);
        n_wrap.row     = ROW_W'(row_w);
        n_wrap.flip    = ROW_W'(flip_w);
    end

    //--------------------------------------------------------------------
    // Stage 15: linear address; zero the fields of an invalid direction
    //--------------------------------------------------------------------
    always_comb begin
        n_out.valid   = r_wrap.valid;
        n_out.invalid = r_wrap.invalid;
        if (r_wrap.invalid) begin
            n_out.face = FACE_POS_X;
            n_out.col  = '0;
            n_out.row  = '0;
            n_out.addr = '0;
        end else begin
            n_out.face = r_wrap.face;
            n_out.col  = r_wrap.col;
            n_out.row  = r_wrap.row;
            n_out.addr = ADDR_W'(ADDR_W'(r_wrap.flip) * ADDR_W'(r_face_w)
                                 + ADDR_W'(r_wrap.col));
        end
    end

    //--------------------------------------------------------------------
    // Pipeline registers
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= '0;
            r_wrap <= '0;
            r_out  <= '0;
            for (int i = 0; i <= QUO_W; i++) begin
                r_dv[i] <= '0;
            end
        end else if (w_adv) begin
            r_sel  <= n_sel;
            r_wrap <= n_wrap;
            r_out  <= n_out;
            for (int i = 0; i <= QUO_W; i++) begin
                r_dv[i] <= n_dv[i];
            end
        end
    end

    assign o_res.valid         = r_out.valid;
    assign o_res.invalid       = r_out.invalid;
    assign o_res.cube_face     = r_out.face;
    assign o_res.texel_col     = r_out.col;
    assign o_res.texel_row     = r_out.row;
    assign o_res.texel_address = r_out.addr;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.invalid |->
            o_res.cube_face == '0 && o_res.texel_col == '0 &&
            o_res.texel_row == '0 && o_res.texel_address == '0)
        else $error("invalid result carries nonzero fields");

    a_in_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.invalid |->
            DIM_W'(o_res.texel_col) < r_face_w && DIM_W'(o_res.texel_row) < r_face_h)
        else $error("texel coordinate outside the face");

    a_face_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.cube_face <= FACE_NEG_Z)
        else $error("face index out of range");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QUO_W].valid && !r_dv[QUO_W].invalid |->
            r_dv[QUO_W].quo_c <= r_face_w && r_dv[QUO_W].quo_r <= r_face_h)
        else $error("divider quotient exceeds face size");

endmodule
